// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held low.
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/chdec_pkg.sv =====
`timescale 1ns / 1ps

package chdec_pkg;

    // Widths of the chunk size and of the emitted-byte counter
    localparam int SIZE_BITS   = 32;
    localparam int LENGTH_BITS = 32;

    // Result queue; depth must be a power of two and at least two
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error causes
    localparam logic [1:0] CAUSE_NO_DIGITS = 2'd0;
    localparam logic [1:0] CAUSE_OVERFLOW  = 2'd1;
    localparam logic [1:0] CAUSE_TRUNCATED = 2'd2;

    // Characters the parser looks for
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_F   = 8'h46;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_EXT,
        PH_EXT_CR,
        PH_DATA,
        PH_SKIP,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [31:0] total_length;
        logic [1:0]  error_cause;
    } t_result;

    // Up to two results per consumed byte, packed from slot 0
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            h.ok  = 1'b1;
            h.val = 4'(c - CHAR_ZERO);
        end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
            h.ok  = 1'b1;
            h.val = 4'(c - CHAR_LOW_A + 8'd10);
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            h.ok  = 1'b1;
            h.val = 4'(c - CHAR_UP_A + 8'd10);
        end
        return h;
    endfunction

endpackage

// ===== hw/rtl/http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps

// Chunked HTTP body decoder. Takes one body byte per beat (i_in_last on the
// final byte) and returns one result per beat: a payload byte, a done marker
// with the total payload length, or an error. The sustained rate is one byte
// per clock while i_stall is low; a byte that yields two results (its payload
// byte followed by a truncation error) occupies two output beats. An accepted
// byte passes through the input register and then the four-entry result queue
// before its first result appears. o_stall rises only when the queue cannot
// take two more results, which back pressure on i_stall causes. After the last
// byte of a body the decoder is back in its reset state for the next body.

module http_chunked_body_decoder import chdec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_total_length,
    output logic [1:0]  o_error_cause
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic    w_fire, w_room, w_accept, w_pop;
    t_push   w_push;
    t_result w_head;

    assign w_fire   = r_in_valid && w_room;
    assign o_stall  = r_in_valid && !w_room;
    assign w_accept = i_valid && !o_stall;
    assign w_pop    = o_valid && !i_stall;

    // Input register: hold while the queue lacks room for two more results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    chdec_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_push  (w_push)
    );

    chdec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_valid (o_valid),
        .o_room  (w_room),
        .o_head  (w_head)
    );

    assign o_kind         = w_head.kind;
    assign o_out_byte     = w_head.out_byte;
    assign o_total_length = w_head.total_length;
    assign o_error_cause  = w_head.error_cause;

endmodule

// ===== hw/rtl/chdec_core.sv =====
`timescale 1ns / 1ps

module chdec_core import chdec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_push      o_push
);

    t_phase                 r_phase, n_phase;
    logic [SIZE_BITS-1:0]   r_rem,   n_rem;
    logic                   r_seen,  n_seen;
    logic                   r_skip,  n_skip;
    logic [LENGTH_BITS-1:0] r_count, n_count;

    t_hex    w_hex;
    logic    w_a_v, w_b_v;
    t_result w_a, w_b;

    // Decode one byte: next state and up to two results
    always_comb begin
        n_phase = r_phase;
        n_rem   = r_rem;
        n_seen  = r_seen;
        n_skip  = r_skip;
        n_count = r_count;
        w_hex   = hex_value(i_byte);
        w_a_v   = 1'b0;
        w_a     = '0;

        unique case (r_phase)
            PH_SIZE: begin
                if (w_hex.ok) begin
                    if (r_rem[SIZE_BITS-1 -: 4] != 4'd0) begin
                        w_a_v         = 1'b1;
                        w_a.kind      = KIND_ERROR;
                        w_a.error_cause = CAUSE_OVERFLOW;
                        n_phase       = PH_ERROR;
                    end else begin
                        n_rem  = {r_rem[SIZE_BITS-5:0], w_hex.val};
                        n_seen = 1'b1;
                    end
                end else if (!r_seen) begin
                    w_a_v           = 1'b1;
                    w_a.kind        = KIND_ERROR;
                    w_a.error_cause = CAUSE_NO_DIGITS;
                    n_phase         = PH_ERROR;
                end else begin
                    n_phase = (i_byte == CHAR_CR) ? PH_EXT_CR : PH_EXT;
                end
            end
            PH_EXT: begin
                if (i_byte == CHAR_CR) n_phase = PH_EXT_CR;
            end
            PH_EXT_CR: begin
                if (i_byte == CHAR_LF) begin
                    if (r_rem == '0) begin
                        w_a_v    = 1'b1;
                        w_a.kind = KIND_DONE;
                        n_phase  = PH_DONE;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else if (i_byte != CHAR_CR) begin
                    n_phase = PH_EXT;
                end
            end
            PH_DATA: begin
                // saturate the emitted-byte counter
                if (r_count != '1) n_count = r_count + 1'b1;
                w_a_v        = 1'b1;
                w_a.kind     = KIND_BYTE;
                w_a.out_byte = i_byte;
                n_rem        = r_rem - 1'b1;
                if (n_rem == '0) begin
                    n_phase = PH_SKIP;
                    n_skip  = 1'b0;
                end
            end
            PH_SKIP: begin
                if (r_skip) begin
                    n_phase = PH_SIZE;
                    n_skip  = 1'b0;
                    n_seen  = 1'b0;
                    n_rem   = '0;
                end else begin
                    n_skip = 1'b1;
                end
            end
            default: ;
        endcase

        w_a.total_length = 32'(n_count);

        // Body ends before done or error: report truncation
        w_b_v            = i_last && n_phase != PH_DONE && n_phase != PH_ERROR;
        w_b              = '0;
        w_b.kind         = KIND_ERROR;
        w_b.error_cause  = CAUSE_TRUNCATED;
        w_b.total_length = 32'(n_count);

        // Last byte of a body: start over for the next one
        if (i_last) begin
            n_phase = PH_SIZE;
            n_rem   = '0;
            n_seen  = 1'b0;
            n_skip  = 1'b0;
            n_count = '0;
        end

        // Pack results from slot 0
        o_push.cnt  = i_fire ? (2'(w_a_v) + 2'(w_b_v)) : 2'd0;
        o_push.res0 = w_a_v ? w_a : w_b;
        o_push.res1 = w_b;
    end

    // Advance state on each consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_rem   <= '0;
            r_seen  <= 1'b0;
            r_skip  <= 1'b0;
            r_count <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_seen  <= n_seen;
            r_skip  <= n_skip;
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/chdec_queue.sv =====
`timescale 1ns / 1ps

module chdec_queue import chdec_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_valid,
    output logic    o_room,
    output t_result o_head
);

    t_result           r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign o_head  = r_q[r_rd];

    // Store up to two results per cycle
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_q[r_wr] <= i_push.res0;
        if (i_push.cnt == 2'd2) r_q[r_wr + QPTR_W'(1)] <= i_push.res1;
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QPTR_W'(i_push.cnt);
            if (i_pop) r_rd <= r_rd + QPTR_W'(1);
            r_cnt <= r_cnt + QCNT_W'(i_push.cnt) - QCNT_W'(i_pop);
        end
    end

endmodule

// ===== hw/rtl/chdec_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chdec_checker import chdec_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_in_byte,
    input logic        i_in_last,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_out_byte,
    input logic [31:0] o_total_length,
    input logic [1:0]  o_error_cause
);

    // A stalled result beat keeps its payload
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_out_byte) && $stable(o_total_length), "stalled result changed")

    // Only error results carry a cause
    `CHK_ASSERT(a_cause_zero, i_clk, i_rst_n, o_valid && o_kind != KIND_ERROR |-> o_error_cause == CAUSE_NO_DIGITS, "cause set on non-error result")

    // Only payload results carry a byte
    `CHK_ASSERT(a_byte_zero, i_clk, i_rst_n, o_valid && o_kind != KIND_BYTE |-> o_out_byte == 8'd0, "byte set on non-payload result")

    // Back-to-back payload beats count up by at most one, or restart at one
    `CHK_ASSERT(a_count_step, i_clk, i_rst_n, o_valid && !i_stall && o_kind == KIND_BYTE ##1 o_valid && o_kind == KIND_BYTE |-> o_total_length == $past(o_total_length) + 32'd1 || o_total_length == 32'd1 || o_total_length == $past(o_total_length), "payload count jumped")

    // Nothing leaves right after reset
    `CHK_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid && !o_stall, "activity right after reset")

endmodule

bind http_chunked_body_decoder chdec_checker u_chdec_checker (.*);

// ===== dv/http_chunked_body_decoder_tb.sv =====
`timescale 1ns / 1ps

module http_chunked_body_decoder_tb;
    import chdec_pkg::*;

    localparam int CLK_PERIOD = 12;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_in_byte = 8'd0;
    logic        i_in_last = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic [31:0] o_total_length;
    logic [1:0]  o_error_cause;

    // Stimulus beats and the results they must produce
    t_beat      pending_beats[$];
    logic [7:0] body_buf[$];
    t_result    expected_results[$];
    t_result    want;
    int         mismatch_cnt = 0;

    // Decoder state mirrored by the predictor
    t_phase                 pr_phase;
    logic [SIZE_BITS-1:0]   pr_chunk_left;
    logic                   pr_have_digit;
    logic                   pr_skip_second;
    logic [LENGTH_BITS-1:0] pr_byte_count;

    // Pacing of both sides
    int   send_wait = 0;
    bit   send_idle_en = 1'b1;
    int   recv_wait = 0;
    bit   recv_idle_en = 1'b1;
    int   run_cycles = 0;
    int   hold_left = 0;
    logic hold_long;

    assign hold_long = (hold_left != 0);

    http_chunked_body_decoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_total_length (o_total_length),
        .o_error_cause  (o_error_cause)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Return {is_digit, value} for a hex character of either case
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            return {1'b1, b[3:0]};
        end
        if ((b >= CHAR_LOW_A && b <= CHAR_LOW_F) || (b >= CHAR_UP_A && b <= CHAR_UP_F)) begin
            return {1'b1, 4'(b[3:0] + 4'd9)};
        end
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10) begin
            return CHAR_ZERO + 8'(nib);
        end
        return (upper ? CHAR_UP_A : CHAR_LOW_A) + 8'(nib) - 8'd10;
    endfunction

    function automatic void clear_decoder();
        pr_phase       = PH_SIZE;
        pr_chunk_left  = '0;
        pr_have_digit  = 1'b0;
        pr_skip_second = 1'b0;
        pr_byte_count  = '0;
    endfunction

    function automatic void queue_result(input logic [1:0] kind, input logic [7:0] data,
                                         input logic [1:0] cause);
        t_result r;
        r.kind         = kind;
        r.out_byte     = data;
        r.total_length = pr_byte_count[31:0];
        r.error_cause  = cause;
        expected_results.push_back(r);
    endfunction

    // Advance the mirrored decoder by one body byte and queue its results
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        logic [4:0] digit;
        digit = hex_digit(b);
        case (pr_phase)
            PH_SIZE: begin
                if (digit[4]) begin
                    if (pr_chunk_left[SIZE_BITS-1 -: 4] != 4'd0) begin
                        queue_result(KIND_ERROR, 8'd0, CAUSE_OVERFLOW);
                        pr_phase = PH_ERROR;
                    end else begin
                        pr_chunk_left = {pr_chunk_left[SIZE_BITS-5:0], digit[3:0]};
                        pr_have_digit = 1'b1;
                    end
                end else if (!pr_have_digit) begin
                    queue_result(KIND_ERROR, 8'd0, CAUSE_NO_DIGITS);
                    pr_phase = PH_ERROR;
                end else begin
                    pr_phase = (b == CHAR_CR) ? PH_EXT_CR : PH_EXT;
                end
            end
            PH_EXT: begin
                if (b == CHAR_CR) pr_phase = PH_EXT_CR;
            end
            PH_EXT_CR: begin
                if (b == CHAR_LF) begin
                    if (pr_chunk_left == '0) begin
                        queue_result(KIND_DONE, 8'd0, CAUSE_NO_DIGITS);
                        pr_phase = PH_DONE;
                    end else begin
                        pr_phase = PH_DATA;
                    end
                end else if (b != CHAR_CR) begin
                    pr_phase = PH_EXT;
                end
            end
            PH_DATA: begin
                if (pr_byte_count != '1) pr_byte_count++;
                queue_result(KIND_BYTE, b, CAUSE_NO_DIGITS);
                pr_chunk_left--;
                if (pr_chunk_left == '0) begin
                    pr_phase       = PH_SKIP;
                    pr_skip_second = 1'b0;
                end
            end
            PH_SKIP: begin
                if (pr_skip_second) begin
                    pr_phase       = PH_SIZE;
                    pr_skip_second = 1'b0;
                    pr_have_digit  = 1'b0;
                    pr_chunk_left  = '0;
                end else begin
                    pr_skip_second = 1'b1;
                end
            end
            default: begin
            end
        endcase
        // A body that ends unfinished reports truncation after any payload byte
        if (last) begin
            if (pr_phase != PH_DONE && pr_phase != PH_ERROR) begin
                queue_result(KIND_ERROR, 8'd0, CAUSE_TRUNCATED);
            end
            clear_decoder();
        end
    endfunction

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) body_buf.push_back(s[k]);
    endtask

    task automatic add_crlf();
        body_buf.push_back(CHAR_CR);
        body_buf.push_back(CHAR_LF);
    endtask

    // Append one chunk: size line with optional extension, data, and for a nonzero size two trailing bytes
    task automatic add_chunk(input int size);
        logic       upper;
        logic [7:0] b;
        upper = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) body_buf.push_back(CHAR_ZERO);
        if (size >= 16) body_buf.push_back(hex_char(4'(size >> 4), upper));
        body_buf.push_back(hex_char(4'(size & 15), upper));
        if ($urandom_range(0, 3) == 0) begin
            body_buf.push_back(";");
            repeat ($urandom_range(0, 4)) begin
                do b = 8'($urandom); while (b == CHAR_CR);
                body_buf.push_back(b);
            end
            // stray CR inside the extension
            if ($urandom_range(0, 3) == 0) begin
                body_buf.push_back(CHAR_CR);
                body_buf.push_back($urandom_range(0, 1) ? CHAR_CR : 8'h78);
            end
        end
        add_crlf();
        repeat (size) body_buf.push_back(8'($urandom));
        if (size != 0) begin
            if ($urandom_range(0, 4) == 0) begin
                body_buf.push_back(8'($urandom));
                body_buf.push_back(8'($urandom));
            end else begin
                add_crlf();
            end
        end
    endtask

    // Move the built body into the beat queue, keeping only a prefix if asked
    task automatic flush_body(input int keep);
        t_beat beat;
        int    n;
        n = (keep == 0) ? body_buf.size() : keep;
        for (int k = 0; k < n; k++) begin
            beat.data = body_buf[k];
            beat.last = (k == n - 1);
            pending_beats.push_back(beat);
        end
        body_buf.delete();
    endtask

    // Sender: present the next beat once the slot is free and the gap has run out
    always @(posedge i_clk) begin
        t_beat beat;
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            i_in_byte <= 8'd0;
            i_in_last <= 1'b0;
            send_wait = 0;
        end else if (!i_valid || !o_stall) begin
            if (send_wait > 0 || pending_beats.size() == 0) begin
                if (send_wait > 0) send_wait--;
                i_valid <= 1'b0;
            end else begin
                beat = pending_beats.pop_front();
                i_valid   <= 1'b1;
                i_in_byte <= beat.data;
                i_in_last <= beat.last;
                if ($urandom_range(0, 39) == 0) send_idle_en = !send_idle_en;
                send_wait = send_idle_en ? $urandom_range(0, 3) : 0;
            end
        end
    end

    // Long receiver hold-off, counted in cycles, to fill the result queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_cycles <= 0;
            hold_left  <= 0;
        end else begin
            run_cycles <= run_cycles + 1;
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end else if (run_cycles % 1500 == 500) begin
                hold_left <= 160;
            end
        end
    end

    // Receiver: check each result beat, then predict from the accepted input beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            clear_decoder();
            expected_results.delete();
            recv_wait = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("unexpected result: kind=%0d byte=%02h len=%0d cause=%0d",
                                 o_kind, o_out_byte, o_total_length, o_error_cause);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (o_kind !== want.kind || o_out_byte !== want.out_byte ||
                        o_total_length !== want.total_length ||
                        o_error_cause !== want.error_cause) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("mismatch: expected kind=%0d byte=%02h len=%0d cause=%0d",
                                     want.kind, want.out_byte, want.total_length,
                                     want.error_cause);
                            $display("          got      kind=%0d byte=%02h len=%0d cause=%0d",
                                     o_kind, o_out_byte, o_total_length, o_error_cause);
                        end
                    end
                end
                if ($urandom_range(0, 39) == 0) recv_idle_en = !recv_idle_en;
                recv_wait = recv_idle_en ? $urandom_range(0, 3) : 0;
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            if (i_valid && !o_stall) decode_byte(i_in_byte, i_in_last);
            i_stall <= hold_long || (recv_wait > 0);
        end
    end

    initial begin
        int         pick;
        logic [7:0] b;
        logic [4:0] info;

        // Data byte extremes, an extension, and a zero chunk followed by ignored bytes
        add_text("2;x");
        add_crlf();
        body_buf.push_back(8'h00);
        body_buf.push_back(8'hFF);
        add_crlf();
        add_text("0");
        add_crlf();
        add_crlf();
        flush_body(0);
        // No size digits
        add_text("g");
        flush_body(0);
        // Size too wide, mixed letter case
        add_text("FfFfFfFfA");
        flush_body(0);
        // Body ends inside the data: payload byte plus truncation
        add_text("1");
        add_crlf();
        add_text("Z");
        flush_body(0);

        while (pending_beats.size() < 875) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // well-formed body, sometimes cut short
                repeat ($urandom_range(1, 3)) begin
                    add_chunk(($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                                          : $urandom_range(1, 8));
                end
                add_chunk(0);
                repeat ($urandom_range(0, 2)) body_buf.push_back(8'($urandom));
                flush_body(($urandom_range(0, 4) == 0) ? $urandom_range(1, body_buf.size() - 1)
                                                       : 0);
            end else if (pick < 80) begin
                // size field opens with a non-hex byte
                do begin
                    b = 8'($urandom);
                    info = hex_digit(b);
                end while (info[4]);
                body_buf.push_back(b);
                repeat ($urandom_range(0, 3)) body_buf.push_back(8'($urandom));
                flush_body(0);
            end else if (pick < 88) begin
                // long size field, at or beyond the width limit
                body_buf.push_back(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
                repeat ($urandom_range(7, 10)) begin
                    body_buf.push_back(hex_char(4'($urandom_range(0, 15)),
                                                1'($urandom_range(0, 1))));
                end
                repeat ($urandom_range(0, 2)) body_buf.push_back(8'($urandom));
                flush_body(0);
            end else begin
                // noise
                repeat ($urandom_range(1, 6)) body_buf.push_back(8'($urandom));
                flush_body(0);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all beats sent and every queued result seen
        while (pending_beats.size() != 0 || i_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("http_chunked_body_decoder regression: pass");
        end else begin
            $display("http_chunked_body_decoder regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("http_chunked_body_decoder regression: fail");
        $finish;
    end

endmodule
